FILE: hw/rtl/sia_pkg.sv
// Shared types, constants and helpers for the signed integer to ASCII block.
// No dependencies; imported by every module of the block.
`default_nettype none
package sia_pkg;
	localparam int VALUE_W     = 32;
	localparam int BCD_DIGITS  = 10;
	localparam int BCD_W       = 4 * BCD_DIGITS;
	localparam int CHAR_W      = 8;
	localparam int SHIFT_STEPS = VALUE_W;
	localparam int CNT_W       = $clog2(SHIFT_STEPS);
	localparam int LEFT_W      = $clog2(BCD_DIGITS + 1);

	localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'd48;
	localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'd45;

	// converter result handed to the character emitter
	typedef struct packed {
		logic             done;
		logic [BCD_W-1:0] bcd;
	} bcd_res_t;

	typedef enum logic [1:0] {
		EM_IDLE,
		EM_SKIP,
		EM_SIGN,
		EM_DIGIT
	} emit_state_t;

	// double-dabble correction of one BCD digit
	function automatic logic [3:0] add3(input logic [3:0] d);
		add3 = (d >= 4'd5) ? 4'(d + 4'd3) : d;
	endfunction
endpackage
`default_nettype wire

FILE: hw/rtl/signed_int_to_decimal_ascii.sv
// Top level: signed 32-bit integer to decimal ASCII text.
// Depends on sia_pkg, sia_dabble and sia_emit.
//
// Usage:
//  - Request channel: a number is taken at a rising edge with start high
//    and busy low. busy stays high until the last character has gone out.
//  - Result channel: one character per cycle in which text_valid is high;
//    is_last marks the final character. The receiver cannot stall, so each
//    character is present for exactly one cycle.
//  - Text is '-' for negative values, then the magnitude without leading
//    zeros; zero gives "0"; -2147483648 is emitted in full.
//  - Timing: the bit-serial converter runs shift-and-add-3 over all 32 input
//    bits, then hands off to the character sequencer, which drops leading
//    zeros one at a time (up to 9), checks the top digit, then sends the
//    characters (1 to 11) one at a time.
//  - Only one number is in flight at a time.
//  - Reset (arst_n low) aborts any conversion and drops pending output.
`default_nettype none
module signed_int_to_decimal_ascii
	import sia_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [VALUE_W-1:0] value,
	output logic                    text_valid,
	output logic [CHAR_W-1:0]       text_char,
	output logic                    is_last
);
	logic               busy_q;
	logic               neg_q;
	logic               take;
	logic [VALUE_W-1:0] mag;
	bcd_res_t           res;

	assign take = start && !busy_q;
	assign busy = busy_q;

	// two's complement magnitude; the most negative value maps to 2^31
	assign mag = value[VALUE_W-1] ? (VALUE_W'(0) - value) : value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (take) begin
			busy_q <= 1'b1;
		end else if (text_valid && is_last) begin
			busy_q <= 1'b0;
		end
	end

	// sign is held for the whole request
	always_ff @(posedge clk) begin
		if (take) neg_q <= value[VALUE_W-1];
	end

	sia_dabble u_dabble (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (take),
		.mag    (mag),
		.res    (res)
	);

	sia_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.res        (res),
		.neg        (neg_q),
		.text_valid (text_valid),
		.text_char  (text_char),
		.is_last    (is_last)
	);
endmodule
`default_nettype wire

FILE: hw/rtl/sia_dabble.sv
// Binary to BCD converter: shift-and-add-3, one bit per cycle.
// Depends on sia_pkg.
`default_nettype none
module sia_dabble
	import sia_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               load,
	input  wire logic [VALUE_W-1:0] mag,
	output bcd_res_t                res
);
	logic [VALUE_W-1:0] bin_q;
	logic [BCD_W-1:0]   bcd_q;
	logic [BCD_W-1:0]   adj;
	logic [CNT_W-1:0]   cnt_q;
	logic               run_q;
	logic               done_q;

	always_comb begin
		for (int i = 0; i < BCD_DIGITS; i++) begin
			adj[4*i +: 4] = add3(bcd_q[4*i +: 4]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (load) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(SHIFT_STEPS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bin_q <= mag;
			bcd_q <= '0;
		end else if (run_q) begin
			{bcd_q, bin_q} <= {adj[BCD_W-2:0], bin_q, 1'b0};
		end
	end

	assign res.done = done_q;
	assign res.bcd  = bcd_q;
endmodule
`default_nettype wire

FILE: hw/rtl/sia_emit.sv
// Character emitter: drops leading zeros, sends sign then digits, MSD first.
// Depends on sia_pkg.
`default_nettype none
module sia_emit
	import sia_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire bcd_res_t          res,
	input  wire logic              neg,
	output logic                   text_valid,
	output logic [CHAR_W-1:0]      text_char,
	output logic                   is_last
);
	emit_state_t       state_q, state_d;
	logic [BCD_W-1:0]  bcd_q;
	logic [LEFT_W-1:0] left_q;
	logic              shift;
	logic              valid_d, last_d;
	logic [CHAR_W-1:0] char_d;
	logic [3:0]        top_dig;

	assign top_dig = bcd_q[BCD_W-1 -: 4];

	always_comb begin
		state_d = state_q;
		shift   = 1'b0;
		valid_d = 1'b0;
		last_d  = 1'b0;
		char_d  = ASCII_ZERO;
		case (state_q)
			EM_IDLE: begin
				if (res.done) state_d = EM_SKIP;
			end
			EM_SKIP: begin
				if (top_dig == 4'd0 && left_q > LEFT_W'(1)) begin
					shift = 1'b1;
				end else begin
					state_d = neg ? EM_SIGN : EM_DIGIT;
				end
			end
			EM_SIGN: begin
				valid_d = 1'b1;
				char_d  = ASCII_MINUS;
				state_d = EM_DIGIT;
			end
			EM_DIGIT: begin
				valid_d = 1'b1;
				char_d  = ASCII_ZERO + {4'd0, top_dig};
				shift   = 1'b1;
				if (left_q == LEFT_W'(1)) begin
					last_d  = 1'b1;
					state_d = EM_IDLE;
				end
			end
			default: state_d = EM_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= EM_IDLE;
			text_valid <= 1'b0;
			is_last    <= 1'b0;
		end else begin
			state_q    <= state_d;
			text_valid <= valid_d;
			is_last    <= last_d;
		end
	end

	always_ff @(posedge clk) begin
		text_char <= char_d;
		if (state_q == EM_IDLE && res.done) begin
			bcd_q  <= res.bcd;
			left_q <= LEFT_W'(BCD_DIGITS);
		end else if (shift) begin
			bcd_q  <= {bcd_q[BCD_W-5:0], 4'd0};
			left_q <= left_q - 1'b1;
		end
	end
endmodule
`default_nettype wire
